[hdl/watchpoint_slot_allocator_assert.svh]
// Assertion macros for the watchpoint slot allocator checker
`ifndef WATCHPOINT_SLOT_ALLOCATOR_ASSERT_SVH
`define WATCHPOINT_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WPSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WPSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wpsa_pkg.sv]
// Types, codes and packing constants shared by the watchpoint slot allocator
`default_nettype none

package wpsa_pkg;

  localparam int MAX_SLOTS     = 4;
  localparam int NUM_SLOTS_DEF = 4;
  localparam int ADDR_W        = 64;
  localparam int IMAGE_W       = 32;
  localparam int IN_TDATA_W    = 80;   // 73 bits of fields, padded to bytes
  localparam int OUT_TDATA_W   = 296;  // 290 bits of fields, padded to bytes
  localparam int OUT_PAD_W     = 6;

  localparam logic [IMAGE_W-1:0] IMAGE_BASE = IMAGE_W'(1 << 10);

  typedef enum logic {
    REQ_SET   = 1'b0,
    REQ_CLEAR = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  localparam logic [1:0] RW_WRITE     = 2'd1;
  localparam logic [1:0] RW_READWRITE = 2'd3;
  localparam logic [1:0] KIND_RW      = 2'd3;

  localparam logic [1:0] LEN_CODE_1 = 2'd0;
  localparam logic [1:0] LEN_CODE_2 = 2'd1;
  localparam logic [1:0] LEN_CODE_4 = 2'd3;
  localparam logic [1:0] LEN_CODE_8 = 2'd2;

  typedef struct packed {
    req_type_t          req_type;
    logic [ADDR_W-1:0]  watch_addr;
    logic [3:0]         watch_len;
    logic [1:0]         watch_kind;
    logic [2:0]         clear_slot;
  } req_t;

  typedef struct packed {
    status_t                          status;
    logic [1:0]                       granted_slot;
    logic [IMAGE_W-1:0]               control_image;
    logic [MAX_SLOTS-1:0][ADDR_W-1:0] addr_reg;
  } rsp_t;

  function automatic logic [1:0] len_to_code(input logic [3:0] len);
    logic [1:0] code;
    unique case (len)
      4'd1:    code = LEN_CODE_1;
      4'd2:    code = LEN_CODE_2;
      4'd4:    code = LEN_CODE_4;
      4'd8:    code = LEN_CODE_8;
      default: code = LEN_CODE_8;
    endcase
    return code;
  endfunction

  function automatic logic [1:0] kind_to_code(input logic [1:0] kind);
    return (kind == KIND_RW) ? RW_READWRITE : RW_WRITE;
  endfunction

endpackage

`default_nettype wire

[hdl/wpsa_slots.sv]
// Slot file: holds the watchpoint slots, applies one request and builds the result
`default_nettype none

module wpsa_slots #(
  parameter int NUM_SLOTS = wpsa_pkg::NUM_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wpsa_pkg::req_t req,
  input  wire logic          commit,
  output wpsa_pkg::rsp_t     rsp
);

  logic [wpsa_pkg::ADDR_W-1:0] slot_address  [wpsa_pkg::MAX_SLOTS];
  logic [1:0]                  slot_len_code [wpsa_pkg::MAX_SLOTS];
  logic [1:0]                  slot_rw_code  [wpsa_pkg::MAX_SLOTS];
  logic [wpsa_pkg::MAX_SLOTS-1:0] slot_active;
  logic [wpsa_pkg::MAX_SLOTS-1:0] slot_active_next;

  logic       found;
  logic       wr_en;
  logic [1:0] sel;
  logic [1:0] new_len;
  logic [1:0] new_rw;
  logic [1:0] len_now;
  logic [1:0] rw_now;
  logic [wpsa_pkg::ADDR_W-1:0] addr_now;
  wpsa_pkg::status_t status;
  logic [1:0]        granted;

  always_comb begin
    slot_active_next  = slot_active;
    found             = 1'b0;
    sel               = '0;
    status            = wpsa_pkg::ST_DONE;
    granted           = '0;
    new_len           = wpsa_pkg::len_to_code(req.watch_len);
    new_rw            = wpsa_pkg::kind_to_code(req.watch_kind);
    if (req.req_type == wpsa_pkg::REQ_SET) begin
      // lowest free slot wins
      for (int i = 0; i < wpsa_pkg::MAX_SLOTS; i++) begin
        if (i < NUM_SLOTS && !found && !slot_active[i]) begin
          found = 1'b1;
          sel   = 2'(i);
        end
      end
      if (found) begin
        slot_active_next[sel] = 1'b1;
        granted               = sel;
      end else begin
        status = wpsa_pkg::ST_NO_SLOT;
      end
    end else begin
      if (32'(req.clear_slot) < NUM_SLOTS) begin
        slot_active_next[req.clear_slot[1:0]] = 1'b0;
      end else begin
        status = wpsa_pkg::ST_BAD_INDEX;
      end
    end
    wr_en = found;
  end

  // image and address registers reflect the state after this request
  always_comb begin
    rsp.status        = status;
    rsp.granted_slot  = granted;
    rsp.control_image = wpsa_pkg::IMAGE_BASE;
    for (int i = 0; i < wpsa_pkg::MAX_SLOTS; i++) begin
      if (wr_en && sel == 2'(i)) begin
        len_now  = new_len;
        rw_now   = new_rw;
        addr_now = req.watch_addr;
      end else begin
        len_now  = slot_len_code[i];
        rw_now   = slot_rw_code[i];
        addr_now = slot_address[i];
      end
      rsp.addr_reg[i] = '0;
      if (slot_active_next[i]) begin
        rsp.control_image[2*i+1]      = 1'b1;
        rsp.control_image[16+4*i +: 2] = rw_now;
        rsp.control_image[18+4*i +: 2] = len_now;
        rsp.addr_reg[i]               = addr_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else if (commit) begin
      slot_active <= slot_active_next;
    end
  end

  // freed slots keep stale contents; they are masked by slot_active
  always_ff @(posedge clk) begin
    if (commit && wr_en) begin
      slot_address[sel]  <= req.watch_addr;
      slot_len_code[sel] <= new_len;
      slot_rw_code[sel]  <= new_rw;
    end
  end

endmodule

`default_nettype wire

[hdl/watchpoint_slot_allocator.sv]
// Top level: request register, slot file and result register of the allocator
//
//  channel  | group    | tuser            | tdata (lowest bit first)
//  ---------+----------+------------------+------------------------------------------
//  request  | s_axis_* | req_type         | watch_addr, watch_len, watch_kind, clear_slot
//  result   | m_axis_* | status           | granted_slot, control_image, addr_reg0..3
//
// One request per cycle when the result side keeps up; a request passes through the
// request register, then the slot update and the result register in one pass, before
// its result is offered.
// Synchronous reset frees every slot and empties both registers.
// A stalled result holds; the request register still drains into it as it is taken.
`default_nettype none

module watchpoint_slot_allocator #(
  parameter int NUM_SLOTS = wpsa_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // watch_addr[63:0], watch_len[67:64], watch_kind[69:68], clear_slot[72:70], zero pad
  input  wire logic [wpsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[0]
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // granted_slot[1:0], control_image[33:2], addr_reg0[97:34], addr_reg1[161:98],
  // addr_reg2[225:162], addr_reg3[289:226], zero pad
  output logic [wpsa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // status[1:0]
  output logic [1:0]                            m_axis_tuser
);

  logic           in_valid;
  wpsa_pkg::req_t in_req;
  logic           out_valid;
  wpsa_pkg::rsp_t out_rsp;
  wpsa_pkg::rsp_t rsp_next;
  logic           advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req.req_type   <= wpsa_pkg::req_type_t'(s_axis_tuser);
      in_req.watch_addr <= s_axis_tdata[63:0];
      in_req.watch_len  <= s_axis_tdata[67:64];
      in_req.watch_kind <= s_axis_tdata[69:68];
      in_req.clear_slot <= s_axis_tdata[72:70];
    end
  end

  wpsa_slots #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slots (
    .clk    (clk),
    .rst    (rst),
    .req    (in_req),
    .commit (advance),
    .rsp    (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp <= rsp_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_rsp.status;
  assign m_axis_tdata  = {
    {wpsa_pkg::OUT_PAD_W{1'b0}},
    out_rsp.addr_reg[3],
    out_rsp.addr_reg[2],
    out_rsp.addr_reg[1],
    out_rsp.addr_reg[0],
    out_rsp.control_image,
    out_rsp.granted_slot
  };

endmodule

`default_nettype wire

[hdl/wpsa_checker.sv]
// Port-level checker for the watchpoint slot allocator, bound to the top level
`default_nettype none

`include "watchpoint_slot_allocator_assert.svh"

module wpsa_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [wpsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]                      m_axis_tuser
);

  logic img_base_ok;
  logic fail_no_grant;
  logic idle_addr_zero;

  assign img_base_ok   = m_axis_tdata[12] && (m_axis_tdata[2 +: 10] & 10'h155) == 10'h0;
  assign fail_no_grant = m_axis_tuser == wpsa_pkg::ST_DONE || m_axis_tdata[1:0] == 2'd0;
  // a slot without its global enable shows a zero address register
  assign idle_addr_zero =
    (m_axis_tdata[3]  || m_axis_tdata[97:34]   == 64'd0) &&
    (m_axis_tdata[5]  || m_axis_tdata[161:98]  == 64'd0) &&
    (m_axis_tdata[7]  || m_axis_tdata[225:162] == 64'd0) &&
    (m_axis_tdata[9]  || m_axis_tdata[289:226] == 64'd0);

  `WPSA_ASSERT_NOW(a_image_base, clk, rst, m_axis_tvalid, img_base_ok, "control image base bits wrong")
  `WPSA_ASSERT_NOW(a_fail_no_grant, clk, rst, m_axis_tvalid, fail_no_grant, "failed request reports a slot")
  `WPSA_ASSERT_NOW(a_idle_addr_zero, clk, rst, m_axis_tvalid, idle_addr_zero, "inactive slot shows an address")
  `WPSA_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result transfer changed")

endmodule

bind watchpoint_slot_allocator wpsa_checker u_wpsa_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the watchpoint slot allocator: stream driver, monitor and predictor
`timescale 1ns / 1ps

module testbench;
  import wpsa_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    req_t req;
    bit   drain;   // hold off until every outstanding result has come back
    bit   burst;   // no gap after this transfer
  } stim_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  stim_t stim_q[$];
  rsp_t  expected_rsp_q[$];

  // predictor copy of the slot file
  logic [ADDR_W-1:0] wp_addr [MAX_SLOTS];
  logic [1:0]        wp_len  [MAX_SLOTS];
  logic [1:0]        wp_rw   [MAX_SLOTS];
  bit                wp_on   [MAX_SLOTS];

  int   error_cnt = 0;
  int   accepted_cnt = 0;
  int   results_seen = 0;
  int   n_grant = 0, n_full = 0, n_clear = 0, n_bad = 0;
  req_t cur_req;
  int   tx_gap = 0;
  int   rx_gap = 0;
  bit   rx_steady = 1'b0;

  watchpoint_slot_allocator #(
    .NUM_SLOTS(SLOTS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [1:0] encode_len(input logic [3:0] len);
    case (len)
      4'd1:    return LEN_CODE_1;
      4'd2:    return LEN_CODE_2;
      4'd4:    return LEN_CODE_4;
      default: return LEN_CODE_8;
    endcase
  endfunction

  // updates the slot file for one request and returns the result it implies
  function automatic rsp_t apply_request(input req_t r);
    rsp_t e;
    bit   found;
    e = '0;
    e.status = ST_DONE;
    found = 1'b0;
    if (r.req_type == REQ_SET) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && !wp_on[i]) begin
          wp_addr[i] = r.watch_addr;
          wp_len[i]  = encode_len(r.watch_len);
          wp_rw[i]   = (r.watch_kind == KIND_RW) ? RW_READWRITE : RW_WRITE;
          wp_on[i]   = 1'b1;
          e.granted_slot = 2'(i);
          found = 1'b1;
        end
      end
      if (!found) e.status = ST_NO_SLOT;
      else n_grant++;
    end else if (int'(r.clear_slot) < SLOTS) begin
      wp_on[r.clear_slot] = 1'b0;
      n_clear++;
    end else begin
      e.status = ST_BAD_INDEX;
    end
    e.control_image = IMAGE_BASE;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (i < SLOTS && wp_on[i]) begin
        e.control_image[2*i+1]      = 1'b1;
        e.control_image[16+4*i +: 2] = wp_rw[i];
        e.control_image[18+4*i +: 2] = wp_len[i];
        e.addr_reg[i] = wp_addr[i];
      end
    end
    return e;
  endfunction

  task automatic note_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v)
      note_error($sformatf("%s: expected %h, got %h", name, exp_v, act_v));
  endtask

  task automatic add_req(input req_type_t rt, input logic [63:0] a, input logic [3:0] l,
                         input logic [1:0] k, input logic [2:0] s,
                         input bit drain = 1'b0, input bit burst = 1'b0);
    stim_t t;
    t.req.req_type   = rt;
    t.req.watch_addr = a;
    t.req.watch_len  = l;
    t.req.watch_kind = k;
    t.req.clear_slot = s;
    t.drain = drain;
    t.burst = burst;
    stim_q.push_back(t);
  endtask

  function automatic logic [63:0] rand_addr();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request side
  always @(posedge clk) begin
    stim_t item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsp_q.push_back(apply_request(cur_req));
        accepted_cnt++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (stim_q.size() != 0 &&
                     !(stim_q[0].drain && accepted_cnt != results_seen)) begin
          item = stim_q.pop_front();
          cur_req = item.req;
          s_axis_tdata  <= {7'b0, item.req.clear_slot, item.req.watch_kind,
                            item.req.watch_len, item.req.watch_addr};
          s_axis_tuser  <= item.req.req_type;
          s_axis_tvalid <= 1'b1;
          tx_gap = item.burst ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (expected_rsp_q.size() == 0) begin
          note_error("result transfer with nothing expected");
        end else begin
          e = expected_rsp_q.pop_front();
          check_field("status", 64'(e.status), 64'(m_axis_tuser));
          check_field("granted_slot", 64'(e.granted_slot), 64'(m_axis_tdata[1:0]));
          check_field("control_image", 64'(e.control_image), 64'(m_axis_tdata[33:2]));
          for (int i = 0; i < MAX_SLOTS; i++)
            check_field($sformatf("addr_reg%0d", i), e.addr_reg[i],
                        m_axis_tdata[34+64*i +: 64]);
          case (e.status)
            ST_NO_SLOT:   n_full++;
            ST_BAD_INDEX: n_bad++;
            default: ;
          endcase
        end
      end
      if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
      if (rx_gap != 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap = rx_steady ? 0 : pick_gap();
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      wp_addr[i] = '0;
      wp_len[i]  = '0;
      wp_rw[i]   = '0;
      wp_on[i]   = 1'b0;
    end

    // fill all four slots across every length code and access kind
    add_req(REQ_SET, 64'h0, 4'd1, 2'd0, 3'd0);
    add_req(REQ_SET, '1, 4'd2, 2'd3, 3'd7);
    add_req(REQ_SET, 64'h8000_0000_0000_0000, 4'd4, 2'd1, 3'd5);
    add_req(REQ_SET, 64'h0000_0000_ffff_fff8, 4'd8, 2'd2, 3'd0);
    // all slots taken
    add_req(REQ_SET, 64'hdead_beef_0000_1000, 4'd15, 2'd3, 3'd0);
    // out-of-range clears with junk in the unused fields, then slot 1 is freed
    add_req(REQ_CLEAR, '1, 4'd15, 2'd3, 3'd7);
    add_req(REQ_CLEAR, 64'h1234, 4'd1, 2'd0, 3'd4);
    add_req(REQ_CLEAR, 64'h0, 4'd0, 2'd1, 3'd1, 1'b1);
    // freeing an idle slot is still fine
    add_req(REQ_CLEAR, '1, 4'd8, 2'd2, 3'd1);
    // re-use overwrites the stale entry; odd lengths fall back to the 8-byte code
    add_req(REQ_SET, 64'h5555_5555_5555_5555, 4'd0, 2'd3, 3'd6);
    add_req(REQ_CLEAR, 64'h0, 4'd0, 2'd0, 3'd0, 1'b0, 1'b1);
    add_req(REQ_CLEAR, 64'h0, 4'd0, 2'd0, 3'd2, 1'b0, 1'b1);
    add_req(REQ_CLEAR, 64'h0, 4'd0, 2'd0, 3'd3, 1'b0, 1'b1);
    add_req(REQ_SET, 64'haaaa_aaaa_aaaa_aaaa, 4'd3, 2'd1, 3'd3);
    add_req(REQ_SET, 64'h1, 4'd15, 2'd0, 3'd0);
    add_req(REQ_SET, 64'h2, 4'd5, 2'd3, 3'd1);
    add_req(REQ_CLEAR, 64'h0, 4'd0, 2'd0, 3'd1);
    add_req(REQ_CLEAR, 64'h0, 4'd0, 2'd0, 3'd0);
    add_req(REQ_CLEAR, 64'h0, 4'd0, 2'd0, 3'd2);
    add_req(REQ_CLEAR, 64'h0, 4'd0, 2'd0, 3'd3);
    add_req(REQ_CLEAR, 64'h0, 4'd0, 2'd0, 3'd6);
    add_req(REQ_SET, 64'hffff_ffff_0000_0000, 4'd8, 2'd3, 3'd7);

    // random churn: sets and clears mixed so slots fill and drain repeatedly
    begin
      bit   burst_run;
      int   sel;
      logic [3:0] l;
      burst_run = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (n % 100 == 0) burst_run = ($urandom_range(0, 3) == 0);
        l = ($urandom_range(0, 1) == 0) ? 4'(1 << $urandom_range(0, 3))
                                        : 4'($urandom_range(0, 15));
        sel = $urandom_range(0, 99);
        if (sel < 50)
          add_req(REQ_SET, rand_addr(), l, 2'($urandom_range(0, 3)),
                  3'($urandom_range(0, 7)), (n % 400 == 200), burst_run);
        else if (sel < 90)
          add_req(REQ_CLEAR, rand_addr(), l, 2'($urandom_range(0, 3)),
                  3'($urandom_range(0, SLOTS - 1)), (n % 400 == 200), burst_run);
        else
          add_req(REQ_CLEAR, rand_addr(), l, 2'($urandom_range(0, 3)),
                  3'($urandom_range(SLOTS, 7)), (n % 400 == 200), burst_run);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
      #1;
    end while (stim_q.size() != 0 || s_axis_tvalid || expected_rsp_q.size() != 0);
    repeat (10) @(posedge clk);
    #1;

    if (expected_rsp_q.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_rsp_q.size()));
    $display("Covered %0d requests: %0d slots granted, %0d slots freed, %0d out-of-range clears,",
             accepted_cnt, n_grant, n_clear, n_bad);
    $display("%0d sets refused on a full file, %0d results checked, %0d mismatches",
             n_full, results_seen, error_cnt);
    if (error_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/wpsa_pkg.sv
hdl/wpsa_slots.sv
hdl/watchpoint_slot_allocator.sv
hdl/wpsa_checker.sv
tb/sv/testbench.sv
